// File: hdl/kdwm_pkg.sv
// Shared types and constants for the kiwi drive wheel mixer.
// Used by the rotation cells, the mixer, the divider cells and the top level.
// No dependencies.
package kdwm_pkg;

  // Sample format and quotient width of the scaling divider
  localparam int SAMPLE_BITS = 16;
  localparam int QBITS       = 16;

  // Q0.31 gain of the rotator and Q.30 value of 1/sqrt3
  localparam logic signed [31:0] K_GAIN    = 32'sd1304065748;
  localparam logic signed [31:0] INV_SQRT3 = 32'sd619925131;
  localparam logic        [35:0] ONE_Q30   = 36'd1073741824;

  // Word carried along the rotation chain
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic signed [15:0] x_raw;
    logic signed [15:0] y_raw;
    logic signed [15:0] t_raw;
    logic               field_rel;
  } rot_t;

  // Word carried along the divider chain
  typedef struct packed {
    logic        [31:0]       m;
    logic [2:0][47:0]         rem;
    logic [2:0][15:0]         q;
    logic [2:0]               neg;
    logic                     big;
    logic [2:0][15:0]         usat;
  } div_t;

  // Arctangent of 2^-idx, 2^32 units per turn
  function automatic logic [31:0] atan_step(input int unsigned idx);
    logic [31:0] r;
    unique case (idx)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2F9;
      15: r = 32'h0000517C;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A2F;  19: r = 32'h00000517;  20: r = 32'h0000028B;
      21: r = 32'h00000145;  22: r = 32'h000000A2;  23: r = 32'h00000051;
      24: r = 32'h00000028;  25: r = 32'h00000014;  26: r = 32'h0000000A;
      27: r = 32'h00000005;  28: r = 32'h00000002;  29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/kdwm_rot_cell.sv
// One CORDIC micro-rotation cell of the heading rotator.
// Depends on kdwm_pkg (rot_t, atan_step).
module kdwm_rot_cell
  import kdwm_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic en,
  input  rot_t d_i,
  output rot_t d_o
);

  localparam logic signed [33:0] ATAN = $signed({2'b00, atan_step(STEP)});

  rot_t nxt;

  // Rotate toward zero residual angle
  always_comb begin
    nxt = d_i;
    if (!d_i.z[33]) begin
      nxt.x = d_i.x - (d_i.y >>> STEP);
      nxt.y = d_i.y + (d_i.x >>> STEP);
      nxt.z = d_i.z - ATAN;
    end else begin
      nxt.x = d_i.x + (d_i.y >>> STEP);
      nxt.y = d_i.y - (d_i.x >>> STEP);
      nxt.z = d_i.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= nxt;
    end
  end

endmodule

// File: hdl/kdwm_div_cell.sv
// One restoring-division cell: yields one quotient bit for all three wheels.
// Depends on kdwm_pkg (div_t).
module kdwm_div_cell
  import kdwm_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic clk,
  input  logic en,
  input  div_t d_i,
  output div_t d_o
);

  div_t        nxt;
  logic [47:0] dv;

  // Subtract the shifted divisor where it fits
  always_comb begin
    nxt = d_i;
    dv  = {16'b0, d_i.m} << BIT;
    for (int k = 0; k < 3; k++) begin
      if (d_i.rem[k] >= dv) begin
        nxt.rem[k]    = d_i.rem[k] - dv;
        nxt.q[k][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= nxt;
    end
  end

endmodule

// File: hdl/kdwm_mix.sv
// Four-stage wheel mixer: constant products, wheel sums, magnitudes, peak and dividend.
// Depends on kdwm_pkg (rot_t, div_t, constants).
module kdwm_mix
  import kdwm_pkg::*;
(
  input  logic       clk,
  input  logic [3:0] en,
  input  rot_t       d_i,
  output div_t       d_o
);

  // Stage 1: products by 1/sqrt3
  logic signed [31:0] x_sel, y_sel;
  logic signed [63:0] px_r;
  logic signed [47:0] pt_r;
  logic signed [31:0] y1_r;

  always_comb begin
    if (d_i.field_rel) begin
      x_sel = d_i.x[31:0];
      y_sel = d_i.y[31:0];
    end else begin
      x_sel = {d_i.x_raw[15], d_i.x_raw, 15'b0};
      y_sel = {d_i.y_raw[15], d_i.y_raw, 15'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_r <= 64'(x_sel) * 64'(INV_SQRT3);
      pt_r <= 48'(d_i.t_raw) * 48'(INV_SQRT3);
      y1_r <= y_sel;
    end
  end

  // Stage 2: round products and form the three wheel sums
  logic signed [63:0] px_rnd, px2_rnd;
  logic signed [47:0] pt_rnd;
  logic signed [35:0] ts, xs, x2, yy;
  logic signed [35:0] w_r [3];

  always_comb begin
    px_rnd  = (px_r + 64'sd536870912) >>> 30;
    px2_rnd = (px_r + 64'sd268435456) >>> 29;
    pt_rnd  = (pt_r + 48'sd16384) >>> 15;
    ts = px_rnd[35:0];
    xs = ts;
    ts = pt_rnd[35:0];
    xs = px_rnd[35:0];
    x2 = px2_rnd[35:0];
    yy = 36'(y1_r);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      w_r[0] <= -ts - xs - yy;
      w_r[1] <= -ts - xs + yy;
      w_r[2] <= -ts + x2;
    end
  end

  // Stage 3: magnitudes, signs and the unscaled saturated results
  logic [2:0][31:0] mag_r;
  logic [2:0]       neg_r;
  logic [2:0][15:0] usat_r;
  logic signed [35:0] rs [3];
  logic        [35:0] am [3];
  logic [2:0][15:0]   us;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      am[k] = w_r[k][35] ? 36'(-w_r[k]) : 36'(w_r[k]);
      rs[k] = (w_r[k] + 36'sd16384) >>> 15;
      if (rs[k] > 36'sd32767) begin
        us[k] = 16'h7FFF;
      end else if (rs[k] < -36'sd32768) begin
        us[k] = 16'h8000;
      end else begin
        us[k] = rs[k][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        mag_r[k] <= am[k][31:0];
      end
      neg_r  <= {w_r[2][35], w_r[1][35], w_r[0][35]};
      usat_r <= us;
    end
  end

  // Stage 4: peak magnitude and rounded dividends
  logic [31:0] m_ab, m_pk;
  div_t        nxt;

  always_comb begin
    m_ab = (mag_r[1] > mag_r[0]) ? mag_r[1] : mag_r[0];
    m_pk = (mag_r[2] > m_ab) ? mag_r[2] : m_ab;
    nxt.m    = m_pk;
    nxt.big  = {4'b0, m_pk} > ONE_Q30;
    nxt.neg  = neg_r;
    nxt.usat = usat_r;
    for (int k = 0; k < 3; k++) begin
      nxt.rem[k] = {1'b0, mag_r[k], 15'b0} + {17'b0, m_pk[31:1]};
      nxt.q[k]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d_o <= nxt;
    end
  end

endmodule

// File: hdl/kiwi_drive_wheel_mixer.sv
// Kiwi drive wheel mixer top level: stream ports, gain stage, cell chains and output stage.
// Depends on kdwm_pkg, kdwm_rot_cell, kdwm_mix and kdwm_div_cell.
//
// Takes one command word per clock while the input is not blocked and returns one word
// of three wheel drives for it, in order. Stages: one gain stage, a chain of NROT CORDIC
// cells (ROTATE_STEPS, capped) for the field-relative turn, four mixer stages, sixteen
// divider cells that scale the wheels when the peak exceeds 1.0, and the output register.
// Each stage holds its word while the next is full and takes a new word as soon as it is
// empty, so a stalled output only blocks the input once every stage is occupied.
module kiwi_drive_wheel_mixer
  import kdwm_pkg::*;
#(
  parameter int ROTATE_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // move_x, move_y, turn_rate, heading
  input  logic        in_tuser,   // use_heading
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // wheel_a, wheel_b, wheel_c
);

  localparam int NROT = (ROTATE_STEPS > 32) ? 32 : ROTATE_STEPS;
  localparam int NST  = NROT + QBITS + 6;
  localparam int MIX0 = NROT + 1;
  localparam int DIV0 = NROT + 5;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  // Advance a stage when it is empty or its successor advances
  assign en[NST-1] = !v_r[NST-1] || out_tready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign in_tready  = en[0];
  assign out_tvalid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Gain stage: remove CORDIC gain and fold the heading into the right half-plane
  logic signed [15:0] in_x, in_y;
  logic        [15:0] in_hdg;
  logic signed [47:0] gx, gy;
  logic signed [33:0] xk, yk;
  logic               fold;
  rot_t               g_nxt;
  rot_t               rot_q [NROT+1];

  assign in_x   = in_tdata[15:0];
  assign in_y   = in_tdata[31:16];
  assign in_hdg = in_tdata[63:48];

  always_comb begin
    gx   = (48'(in_x) * 48'(K_GAIN)) + 48'sd32768;
    gy   = (48'(in_y) * 48'(K_GAIN)) + 48'sd32768;
    xk   = {{2{gx[47]}}, gx[47:16]};
    yk   = {{2{gy[47]}}, gy[47:16]};
    fold = in_hdg[15] ^ in_hdg[14];
    g_nxt.x         = fold ? -xk : xk;
    g_nxt.y         = fold ? -yk : yk;
    g_nxt.z         = $signed({{2{in_hdg[14]}}, in_hdg[14:0], 17'b0}) >>> 1;
    g_nxt.z[33:31]  = {3{in_hdg[14]}};
    g_nxt.x_raw     = in_x;
    g_nxt.y_raw     = in_y;
    g_nxt.t_raw     = in_tdata[47:32];
    g_nxt.field_rel = in_tuser;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rot_q[0] <= g_nxt;
    end
  end

  // Rotation chain
  for (genvar i = 0; i < NROT; i++) begin : g_rot
    kdwm_rot_cell #(.STEP(i)) u_cell (
      .clk (clk),
      .en  (en[i+1]),
      .d_i (rot_q[i]),
      .d_o (rot_q[i+1])
    );
  end

  // Mixer
  div_t div_q [QBITS+1];

  kdwm_mix u_mix (
    .clk (clk),
    .en  (en[MIX0+3:MIX0]),
    .d_i (rot_q[NROT]),
    .d_o (div_q[0])
  );

  // Divider chain, most significant quotient bit first
  for (genvar j = 0; j < QBITS; j++) begin : g_div
    kdwm_div_cell #(.BIT(QBITS - 1 - j)) u_cell (
      .clk (clk),
      .en  (en[DIV0+j]),
      .d_i (div_q[j]),
      .d_o (div_q[j+1])
    );
  end

  // Output stage: pick scaled or unscaled result and saturate
  div_t             dq;
  logic [2:0][15:0] w_nxt;
  logic [2:0][15:0] w_r;

  assign dq = div_q[QBITS];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!dq.big) begin
        w_nxt[k] = dq.usat[k];
      end else if (dq.neg[k]) begin
        w_nxt[k] = -dq.q[k];
      end else if (dq.q[k][15]) begin
        w_nxt[k] = 16'h7FFF;
      end else begin
        w_nxt[k] = dq.q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      w_r <= w_nxt;
    end
  end

  assign out_tdata = w_r;

`ifndef SYNTHESIS
  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // In a scaled word the peak wheel always reaches full scale
  a_peak_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NST-2] && dq.big) |-> (dq.q[0][15] || dq.q[1][15] || dq.q[2][15]))
    else $error("scaled word has no full-scale wheel");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule

// File: test/tb_kiwi_drive_wheel_mixer.sv
// Testbench for the kiwi drive wheel mixer: drives command words, predicts wheel drives.
// Depends on kdwm_pkg and kiwi_drive_wheel_mixer; compares every output word in order.
module tb_kiwi_drive_wheel_mixer;
  import kdwm_pkg::*;

  localparam int ROT_STEPS = 16;
  localparam int FRACB = 30;
  localparam longint INV3_Q30 = 64'd619925131;
  localparam longint TWO_INV3_Q30 = 64'd1239850262;
  localparam longint GAIN_Q31 = 64'd1304065748;

  typedef struct packed {
    logic [15:0] c;
    logic [15:0] b;
    logic [15:0] a;
  } wheels_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  wheels_t pending_wheels[$];
  int      n_bad = 0;
  bit      quiet;

  kiwi_drive_wheel_mixer #(.ROTATE_STEPS(ROT_STEPS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Clock, period 4
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Arithmetic shift with round half up
  function automatic longint shr_round(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [15:0] clamp16(longint r);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic logic [15:0] scale_by_peak(longint q, longint m);
    longint mag;
    longint r;
    mag = (q < 0) ? -q : q;
    r = (mag * 32768 + m / 2) / m;
    return clamp16((q < 0) ? -r : r);
  endfunction

  // Expected wheel drives for one command
  function automatic wheels_t mix_wheels(logic signed [15:0] mx, logic signed [15:0] my,
                                         logic signed [15:0] tr, logic [15:0] hd,
                                         logic fr);
    longint x, y, t, ts, xs, x2, a, b, c, m, dx, dy, zs;
    logic [31:0] z;
    wheels_t w;
    x = longint'(mx) <<< 15;
    y = longint'(my) <<< 15;
    t = longint'(tr) <<< 15;
    if (fr) begin
      z = {hd, 16'h0};
      x = shr_round(x * GAIN_Q31, 31);
      y = shr_round(y * GAIN_Q31, 31);
      if (z[31:30] == 2'd1 || z[31:30] == 2'd2) begin
        x = -x;
        y = -y;
        z = z + 32'h80000000;
      end
      zs = longint'(signed'(z));
      for (int i = 0; i < ROT_STEPS && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (zs >= 0) begin
          x -= dx; y += dy; zs -= longint'(atan_step(i));
        end else begin
          x += dx; y -= dy; zs += longint'(atan_step(i));
        end
      end
    end
    ts = shr_round(t * INV3_Q30, FRACB);
    xs = shr_round(x * INV3_Q30, FRACB);
    x2 = shr_round(x * TWO_INV3_Q30, FRACB);
    a = -ts - xs - y;
    b = -ts - xs + y;
    c = -ts + x2;
    m = (a < 0) ? -a : a;
    if (((b < 0) ? -b : b) > m) m = (b < 0) ? -b : b;
    if (((c < 0) ? -c : c) > m) m = (c < 0) ? -c : c;
    if (m > (64'sd1 <<< FRACB)) begin
      w.a = scale_by_peak(a, m);
      w.b = scale_by_peak(b, m);
      w.c = scale_by_peak(c, m);
    end else begin
      w.a = clamp16(shr_round(a, 15));
      w.b = clamp16(shr_round(b, 15));
      w.c = clamp16(shr_round(c, 15));
    end
    return w;
  endfunction

  // Send one command word, with random idle cycles unless quiet
  task automatic send_cmd(logic [15:0] mx, logic [15:0] my, logic [15:0] tr,
                          logic [15:0] hd, logic fr);
    while (!quiet && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {hd, tr, my, mx};
    in_tuser <= fr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_wheels.push_back(mix_wheels(mx, my, tr, hd, fr));
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk);
  endtask

  // Zero and pure-y commands, extremes, quadrant edges and alternating bit patterns
  task automatic test_directed();
    logic [15:0] ext[4];
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    send_cmd(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_cmd(16'h0000, 16'h7FFF, 16'h0000, 16'h1234, 1'b0);
    send_cmd(16'h0000, 16'h4000, 16'h0000, 16'h0000, 1'b0);
    send_cmd(16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b0);
    send_cmd(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b1);
    send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1);
    for (int i = 0; i < 4; i++)
      send_cmd(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], 16'(16'h4000 * i), 1'b1);
    send_cmd(16'h4000, 16'h2000, 16'h0000, 16'h3FFF, 1'b1);
    send_cmd(16'h4000, 16'h2000, 16'h0000, 16'hBFFF, 1'b1);
    send_cmd(16'h4000, 16'h2000, 16'h0000, 16'hC000, 1'b1);
    send_cmd(16'h4000, 16'h2000, 16'h0000, 16'h8000, 1'b1);
    send_cmd(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
    send_cmd(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
    drain_results();
  endtask

  // Random commands; small values in part so that the unscaled path is hit
  task automatic test_random(int count);
    logic [15:0] v[3];
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 3; k++)
        v[k] = ($urandom_range(1)) ? 16'($urandom) : 16'($signed($urandom_range(8000)) - 4000);
      send_cmd(v[0], v[1], v[2], 16'($urandom), 1'($urandom));
    end
    idle_input();
  endtask

  // Back-to-back words with no input gaps
  task automatic test_burst(int count);
    quiet = 1'b1;
    test_random(count);
    quiet = 1'b0;
    drain_results();
  endtask

  // Result checker
  always @(posedge clk) begin
    wheels_t got;
    wheels_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_wheels.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        n_bad++;
      end else begin
        want = pending_wheels.pop_front();
        if (got.a !== want.a)
          $display("%0t wheel_a expected %h actual %h", $time, want.a, got.a);
        if (got.b !== want.b)
          $display("%0t wheel_b expected %h actual %h", $time, want.b, got.b);
        if (got.c !== want.c)
          $display("%0t wheel_c expected %h actual %h", $time, want.c, got.c);
        if (got.a !== want.a || got.b !== want.b || got.c !== want.c) n_bad++;
      end
    end
  end

  // Output stall: random, except during quiet stretches
  always @(posedge clk) begin
    if (!rst_n || quiet) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 17);
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    quiet = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(450);
    drain_results();
    test_burst(150);
    test_random(330);
    drain_results();
    repeat (ROT_STEPS + 40) @(posedge clk);
    if (n_bad == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Timeout
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
